// ===== rtl/c2e_pkg.sv =====
// Package with the shared constants and the month table for the calendar-to-epoch converter.
`timescale 1ns / 1ps

package c2e_pkg;

  // Field widths of the request and result.
  localparam int YEAR_W   = 10;
  localparam int MONTH_W  = 8;
  localparam int MDAY_W   = 5;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int EPOCH_W  = 36;

  // Internal widths.
  localparam int FULLYR_W = 12;  // calendar year, 1889..2933
  localparam int DAYS_W   = 21;  // signed day count since the epoch
  localparam int TOD_W    = 17;  // seconds within the (unchecked) day

  // Time constants.
  localparam int SEC_PER_DAY  = 86400;
  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_MIN  = 60;
  localparam int DAYS_PER_YR  = 365;
  localparam int EPOCH_YEAR   = 1970;

  // Leap years counted through 1969: 1969/4 - 1969/100 + 1969/400.
  localparam int LEAPS_1969   = 477;

  // Days in the year before the first of each month, non-leap year.
  function automatic logic [8:0] days_before_month(input logic [3:0] mon);
    logic [8:0] d;
    unique case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/c2e_day_count.sv =====
// Three-stage pipeline that turns a calendar date into a signed day count and a time-of-day sum.
`timescale 1ns / 1ps

module c2e_day_count (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [c2e_pkg::YEAR_W-1:0]          years_since_1900,
  input  logic signed [c2e_pkg::MONTH_W-1:0]  month_index,
  input  logic [c2e_pkg::MDAY_W-1:0]          day_of_month,
  input  logic [c2e_pkg::HOUR_W-1:0]          hour_of_day,
  input  logic [c2e_pkg::MIN_W-1:0]           minute_of_hour,
  input  logic [c2e_pkg::SEC_W-1:0]           second_of_minute,
  output logic                                out_valid,
  output logic signed [c2e_pkg::DAYS_W-1:0]   days,
  output logic [c2e_pkg::TOD_W-1:0]           tod
);

  localparam int YW = c2e_pkg::FULLYR_W;
  localparam int DW = c2e_pkg::DAYS_W;
  localparam int TW = c2e_pkg::TOD_W;

  // ---------------- Stage 1: fold the month into 0..11 ----------------
  // u = month + 132 lies in 4..259; u = 12*k + r and the year carry is k - 11.
  // The quotient by 12 comes from a multiply by 171 / 2048.
  logic [8:0]    mon_u;
  logic [16:0]   mon_prod;
  logic [5:0]    mon_k;
  logic [8:0]    mon_rem;

  logic          s1_valid_r;
  logic [YW-1:0] s1_year_r,  s1_year_nxt;
  logic [3:0]    s1_mon_r,   s1_mon_nxt;
  logic [c2e_pkg::MDAY_W-1:0] s1_mday_r;
  logic [c2e_pkg::HOUR_W-1:0] s1_hour_r;
  logic [c2e_pkg::MIN_W-1:0]  s1_min_r;
  logic [c2e_pkg::SEC_W-1:0]  s1_sec_r;

  always_comb begin
    mon_u       = 9'({1'b0, ~month_index[7], month_index[6:0]}) + 9'd4;
    mon_prod    = 17'(mon_u) * 17'd171;
    mon_k       = mon_prod[16:11];
    mon_rem     = mon_u - 9'(mon_k) * 9'd12;
    s1_mon_nxt  = mon_rem[3:0];
    // year = years_since_1900 + 1900 + k - 11
    s1_year_nxt = YW'(years_since_1900) + YW'(1889) + YW'(mon_k);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_year_r <= s1_year_nxt;
      s1_mon_r  <= s1_mon_nxt;
      s1_mday_r <= day_of_month;
      s1_hour_r <= hour_of_day;
      s1_min_r  <= minute_of_hour;
      s1_sec_r  <= second_of_minute;
    end
  end

  // ---------------- Stage 2: century quotients and linear terms ----------------
  // Division by 100 uses a multiply by 5243 / 2^19, exact for these years.
  logic [YW-1:0]        y1;
  logic [24:0]          c0_prod, c1_prod;
  logic signed [12:0]   yoff;

  logic                 s2_valid_r;
  logic [YW-1:0]        s2_year_r;
  logic [YW-3:0]        s2_q4_r,    s2_q4_nxt;
  logic [4:0]           s2_c0_r,    s2_c0_nxt;
  logic [4:0]           s2_c1_r,    s2_c1_nxt;
  logic signed [DW-1:0] s2_ydays_r, s2_ydays_nxt;
  logic signed [10:0]   s2_base_r,  s2_base_nxt;
  logic                 s2_late_r,  s2_late_nxt;
  logic [TW-1:0]        s2_tod_r,   s2_tod_nxt;

  always_comb begin
    y1           = s1_year_r - YW'(1);
    c0_prod      = 25'(s1_year_r) * 25'd5243;
    c1_prod      = 25'(y1) * 25'd5243;
    s2_c0_nxt    = c0_prod[23:19];
    s2_c1_nxt    = c1_prod[23:19];
    s2_q4_nxt    = y1[YW-1:2];
    yoff         = $signed({1'b0, s1_year_r}) - 13'sd1970;
    s2_ydays_nxt = DW'(yoff) * $signed(DW'(c2e_pkg::DAYS_PER_YR));
    s2_base_nxt  = $signed({2'b00, c2e_pkg::days_before_month(s1_mon_r)})
                 + $signed({6'd0, s1_mday_r}) - 11'sd1;
    // Months after February take the leap day.
    s2_late_nxt  = (s1_mon_r > 4'd1);
    s2_tod_nxt   = TW'(s1_hour_r) * TW'(c2e_pkg::SEC_PER_HOUR)
                 + TW'(s1_min_r) * TW'(c2e_pkg::SEC_PER_MIN)
                 + TW'(s1_sec_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_year_r  <= s1_year_r;
      s2_q4_r    <= s2_q4_nxt;
      s2_c0_r    <= s2_c0_nxt;
      s2_c1_r    <= s2_c1_nxt;
      s2_ydays_r <= s2_ydays_nxt;
      s2_base_r  <= s2_base_nxt;
      s2_late_r  <= s2_late_nxt;
      s2_tod_r   <= s2_tod_nxt;
    end
  end

  // ---------------- Stage 3: leap corrections and the day sum ----------------
  logic signed [12:0]   leaps;
  logic                 cent_year;
  logic                 is_leap;
  logic                 leap_day;

  logic                 s3_valid_r;
  logic signed [DW-1:0] s3_days_r, s3_days_nxt;
  logic [TW-1:0]        s3_tod_r;

  always_comb begin
    // Leap years from 1970 through the year before this one.
    leaps       = $signed({3'b000, s2_q4_r}) - $signed({8'd0, s2_c1_r})
                + $signed({10'd0, s2_c1_r[4:2]}) - 13'sd477;
    cent_year   = (s2_year_r == YW'(s2_c0_r) * YW'(100));
    is_leap     = (s2_year_r[1:0] == 2'b00) && (!cent_year || (s2_c0_r[1:0] == 2'b00));
    leap_day    = s2_late_r && is_leap;
    s3_days_nxt = s2_ydays_r + DW'(leaps) + DW'(s2_base_r)
                + $signed({{(DW-1){1'b0}}, leap_day});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_days_r <= s3_days_nxt;
      s3_tod_r  <= s2_tod_r;
    end
  end

  assign out_valid = s3_valid_r;
  assign days      = s3_days_r;
  assign tod       = s3_tod_r;

endmodule

// ===== rtl/calendar_to_epoch_seconds_core.sv =====
// Top level of the UTC calendar-to-epoch-seconds converter.
`timescale 1ns / 1ps
// Usage:
//   Each request carries years since 1900, a signed month index (folded into
//   0..11 with the carry going into the year), day of month, hour, minute and
//   second. The result is the signed count of seconds since 1970-01-01 UTC.
//   Both channels use valid and stall: a request moves on an edge where valid
//   is high and stall is low.
// Throughput:
//   One request is taken every cycle while no stall holds the pipeline. Each
//   request passes in order through five register stages (month fold, century
//   quotients, day sum, multiply by 86400, final add), each of which holds one
//   request, and its result shows on out_valid from the last. Requests are
//   independent, so only a stall limits the rate.
// Stall:
//   While the output holds a result and out_stall is high, the whole pipeline
//   freezes and in_stall goes high; nothing is dropped or repeated.
// Reset:
//   rst_n is synchronous, active low, and clears all stage valid bits. The
//   block has no state beyond the pipeline and no configuration.

module calendar_to_epoch_seconds_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [c2e_pkg::YEAR_W-1:0]          in_years_since_1900,
  input  logic signed [c2e_pkg::MONTH_W-1:0]  in_month_index,
  input  logic [c2e_pkg::MDAY_W-1:0]          in_day_of_month,
  input  logic [c2e_pkg::HOUR_W-1:0]          in_hour_of_day,
  input  logic [c2e_pkg::MIN_W-1:0]           in_minute_of_hour,
  input  logic [c2e_pkg::SEC_W-1:0]           in_second_of_minute,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [c2e_pkg::EPOCH_W-1:0]  out_epoch_seconds
);

  localparam int DW = c2e_pkg::DAYS_W;
  localparam int TW = c2e_pkg::TOD_W;
  localparam int EW = c2e_pkg::EPOCH_W;
  localparam int PW = DW + 18;

  // The pipeline advances unless a finished result is held up.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Day count and time of day for each request.
  logic                 dc_valid;
  logic signed [DW-1:0] dc_days;
  logic [TW-1:0]        dc_tod;

  c2e_day_count u_day_count (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (en),
    .in_valid         (in_valid),
    .years_since_1900 (in_years_since_1900),
    .month_index      (in_month_index),
    .day_of_month     (in_day_of_month),
    .hour_of_day      (in_hour_of_day),
    .minute_of_hour   (in_minute_of_hour),
    .second_of_minute (in_second_of_minute),
    .out_valid        (dc_valid),
    .days             (dc_days),
    .tod              (dc_tod)
  );

  // Stage 4: scale the day count to seconds.
  logic signed [PW-1:0] day_prod;
  logic                 s4_valid_r;
  logic signed [EW-1:0] s4_sec_r;
  logic [TW-1:0]        s4_tod_r;

  assign day_prod = dc_days * $signed(18'(c2e_pkg::SEC_PER_DAY));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s4_valid_r <= dc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sec_r <= day_prod[EW-1:0];
      s4_tod_r <= dc_tod;
    end
  end

  // Stage 5: add the time of day into the output register.
  logic                 out_valid_r;
  logic signed [EW-1:0] out_sec_r, out_sec_nxt;

  assign out_sec_nxt = s4_sec_r + $signed({{(EW-TW){1'b0}}, s4_tod_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sec_r <= out_sec_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_epoch_seconds = out_sec_r;

endmodule
